/* design/stream_find_replace_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stream find-and-replace block
// Each check compiles to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

`ifndef SYNTHESIS
// check a property on every clock edge outside reset
`define SFR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sfr: assertion failed");
// check a property on every clock edge, during reset too
`define SFR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sfr: assertion failed");
`else
`define SFR_ASSERT(lbl, clk, rst_n, prop)
`define SFR_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* design/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Constants, types and helpers shared by the find-and-replace modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	localparam int PATTERN_MAX = 16;
	localparam int REPLACE_MAX = 32;
	localparam int IDX_W       = $clog2(PATTERN_MAX);
	localparam int FILL_W      = $clog2(PATTERN_MAX + 1);
	localparam int REP_IDX_W   = $clog2(REPLACE_MAX);
	localparam int REP_LEN_W   = 6;
	localparam int PAT_LEN_W   = 5;

	// configuration register indexes
	localparam logic [2:0] REG_PAT_LO  = 3'd0;
	localparam logic [2:0] REG_PAT_HI  = 3'd1;
	localparam logic [2:0] REG_PAT_LEN = 3'd2;
	localparam logic [2:0] REG_REP_W0  = 3'd3;
	localparam logic [2:0] REG_REP_W1  = 3'd4;
	localparam logic [2:0] REG_REP_W2  = 3'd5;
	localparam logic [2:0] REG_REP_W3  = 3'd6;
	localparam logic [2:0] REG_REP_LEN = 3'd7;

	// controls from the sequencer to the window
	typedef struct packed {
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
		logic             shift;
	} win_ctrl_t;

	// status from the window to the sequencer
	typedef struct packed {
		logic       match;
		logic [7:0] oldest;
	} win_stat_t;

	// zero counts as one, clamp at the window depth
	function automatic logic [FILL_W-1:0] pat_len_sat(input logic [PAT_LEN_W-1:0] n);
		logic [FILL_W-1:0] r;
		if (n == '0)
			r = FILL_W'(1);
		else if (32'(n) > PATTERN_MAX)
			r = FILL_W'(PATTERN_MAX);
		else
			r = FILL_W'(n);
		return r;
	endfunction

	function automatic logic [REP_LEN_W-1:0] rep_len_sat(input logic [REP_LEN_W-1:0] n);
		logic [REP_LEN_W-1:0] r;
		if (32'(n) > REPLACE_MAX)
			r = REP_LEN_W'(REPLACE_MAX);
		else
			r = n;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/sfr_cell.sv */
// ----------------------------------------------------------------------------
// sfr_cell
// One window slot: holds a byte, takes its neighbor's byte on a shift and
// compares its byte with the pattern byte of the same position.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_cell (
	input  wire logic       clk,
	input  wire logic       wr,
	input  wire logic       shift,
	input  wire logic [7:0] in_byte,
	input  wire logic [7:0] next_byte,
	input  wire logic [7:0] pat_byte,
	output logic      [7:0] cur_byte,
	output logic            eq
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			byte_q <= in_byte;
		end else if (shift) begin
			byte_q <= next_byte;
		end
	end

	assign cur_byte = byte_q;
	assign eq       = (byte_q == pat_byte);

endmodule

`default_nettype wire

/* design/sfr_window.sv */
// ----------------------------------------------------------------------------
// sfr_window
// Row of window cells, oldest byte in slot 0; reduces the per-slot compares
// over the active pattern length into one match flag.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_window (
	input  wire logic                                 clk,
	input  wire sfr_pkg::win_ctrl_t                   ctrl,
	input  wire logic [7:0]                           in_byte,
	input  wire logic [sfr_pkg::PATTERN_MAX*8-1:0]    pattern,
	input  wire logic [sfr_pkg::FILL_W-1:0]           pat_len,
	output sfr_pkg::win_stat_t                        stat
);

	logic [7:0] slot_byte [sfr_pkg::PATTERN_MAX];
	logic [sfr_pkg::PATTERN_MAX-1:0] slot_ok;

	for (genvar i = 0; i < sfr_pkg::PATTERN_MAX; i++) begin : g_slot
		logic       eq;
		logic [7:0] nb;

		if (i == sfr_pkg::PATTERN_MAX - 1) begin : g_end
			assign nb = 8'h00;
		end else begin : g_mid
			assign nb = slot_byte[i+1];
		end

		sfr_cell u_slot (
			.clk       (clk),
			.wr        (ctrl.wr && (ctrl.wr_idx == sfr_pkg::IDX_W'(i))),
			.shift     (ctrl.shift),
			.in_byte   (in_byte),
			.next_byte (nb),
			.pat_byte  (pattern[i*8 +: 8]),
			.cur_byte  (slot_byte[i]),
			.eq        (eq)
		);

		// slots past the pattern length do not take part
		assign slot_ok[i] = eq || (sfr_pkg::FILL_W'(i) >= pat_len);
	end

	assign stat.match  = &slot_ok;
	assign stat.oldest = slot_byte[0];

endmodule

`default_nettype wire

/* design/stream_find_replace.sv */
// ----------------------------------------------------------------------------
// stream_find_replace
// Rewrites a byte stream, replacing each leftmost non-overlapping pattern
// occurrence with the configured replacement.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                              | beat taken when
//  s_axis   | in  | tdata: data_byte, tlast: end_of_text | tvalid & tready
//  m_axis   | out | tdata: out_byte, tuser: has_byte,    | tvalid & tready
//           |     | tlast: out_last                      |
//  cfg      | in  | cfg_index, cfg_data                  | cfg_valid & cfg_ready
//
// An input beat is taken, then compared; its result beats then leave at one
// per cycle through the single output register, unless the output stalls.
// Results stall while m_axis_tready is low; the next input beat is taken
// while the last result still waits in the output register.
// Reset clears the window fill count and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "stream_find_replace_assert.svh"

module stream_find_replace (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic             m_axis_tuser,   // [0] has_byte
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EVAL = 4'b0010,
		ST_POP  = 4'b0100,
		ST_REPL = 4'b1000
	} state_t;

	state_t state_q;

	logic [63:0] pat_lo_q, pat_hi_q;
	logic [sfr_pkg::PAT_LEN_W-1:0] pat_len_q;
	logic [63:0] rep_w0_q, rep_w1_q, rep_w2_q, rep_w3_q;
	logic [sfr_pkg::REP_LEN_W-1:0] rep_len_q;

	logic [sfr_pkg::FILL_W-1:0]    fill_q;
	logic                          last_q;
	logic [sfr_pkg::REP_IDX_W-1:0] rep_idx_q;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_has_q;
	logic       out_last_q;

	sfr_pkg::win_ctrl_t win_ctrl;
	sfr_pkg::win_stat_t win_stat;

	logic [sfr_pkg::FILL_W-1:0]    len;
	logic [sfr_pkg::FILL_W-1:0]    pop_target;
	logic [sfr_pkg::REP_LEN_W-1:0] rlen;
	logic [255:0]                  rep_all;
	logic                          in_beat, emit_ok;
	logic                          emit;
	logic [7:0]                    emit_byte;
	logic                          emit_has, emit_last;
	logic                          rep_at_end;

	assign len        = sfr_pkg::pat_len_sat(pat_len_q);
	assign rlen       = sfr_pkg::rep_len_sat(rep_len_q);
	assign pop_target = last_q ? '0 : (len - sfr_pkg::FILL_W'(1));
	assign rep_all    = {rep_w3_q, rep_w2_q, rep_w1_q, rep_w0_q};
	assign rep_at_end = ({1'b0, rep_idx_q} == (rlen - sfr_pkg::REP_LEN_W'(1)));

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign emit_ok       = !out_valid_q || m_axis_tready;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= sfr_pkg::PAT_LEN_W'(1);
			rep_w0_q  <= '0;
			rep_w1_q  <= '0;
			rep_w2_q  <= '0;
			rep_w3_q  <= '0;
			rep_len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfr_pkg::REG_PAT_LO:  pat_lo_q  <= cfg_data;
				sfr_pkg::REG_PAT_HI:  pat_hi_q  <= cfg_data;
				sfr_pkg::REG_PAT_LEN: pat_len_q <= cfg_data[sfr_pkg::PAT_LEN_W-1:0];
				sfr_pkg::REG_REP_W0:  rep_w0_q  <= cfg_data;
				sfr_pkg::REG_REP_W1:  rep_w1_q  <= cfg_data;
				sfr_pkg::REG_REP_W2:  rep_w2_q  <= cfg_data;
				sfr_pkg::REG_REP_W3:  rep_w3_q  <= cfg_data;
				sfr_pkg::REG_REP_LEN: rep_len_q <= cfg_data[sfr_pkg::REP_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- window
	always_comb begin
		win_ctrl.wr     = in_beat;
		win_ctrl.wr_idx = fill_q[sfr_pkg::IDX_W-1:0];
		win_ctrl.shift  = (state_q == ST_POP) && emit_ok;
	end

	sfr_window u_window (
		.clk     (clk),
		.ctrl    (win_ctrl),
		.in_byte (s_axis_tdata),
		.pattern ({pat_hi_q, pat_lo_q}),
		.pat_len (len),
		.stat    (win_stat)
	);

	// ------------------------------------------------------------- emission
	always_comb begin
		emit      = 1'b0;
		emit_byte = 8'h00;
		emit_has  = 1'b1;
		emit_last = 1'b0;
		unique case (state_q)
			ST_POP: begin
				emit      = emit_ok;
				emit_byte = win_stat.oldest;
				emit_last = last_q && (fill_q == sfr_pkg::FILL_W'(1));
			end
			ST_REPL: begin
				emit = emit_ok;
				if (rlen == '0) begin
					// bare end marker
					emit_has  = 1'b0;
					emit_last = 1'b1;
				end else begin
					emit_byte = rep_all[rep_idx_q*8 +: 8];
					emit_last = last_q && rep_at_end;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------ sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			last_q    <= 1'b0;
			rep_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						fill_q  <= fill_q + sfr_pkg::FILL_W'(1);
						last_q  <= s_axis_tlast;
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					rep_idx_q <= '0;
					if (fill_q == len && win_stat.match) begin
						fill_q  <= '0;
						state_q <= (rlen == '0 && !last_q) ? ST_IDLE : ST_REPL;
					end else if (fill_q >= len || last_q) begin
						state_q <= ST_POP;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (emit_ok) begin
						fill_q <= fill_q - sfr_pkg::FILL_W'(1);
						if (fill_q - sfr_pkg::FILL_W'(1) == pop_target) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_REPL: begin
					if (emit_ok) begin
						if (rlen == '0 || rep_at_end) begin
							state_q <= ST_IDLE;
						end else begin
							rep_idx_q <= rep_idx_q + sfr_pkg::REP_IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_has_q  <= emit_has;
			out_last_q <= emit_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;

	// ------------------------------------------------------------ assertions
	`SFR_ASSERT(a_fill_bound, clk, arst_n, 32'(fill_q) <= sfr_pkg::PATTERN_MAX)
	`SFR_ASSERT(a_pop_nonempty, clk, arst_n, (state_q == ST_POP) |-> (fill_q != '0))
	`SFR_ASSERT(a_beat_to_eval, clk, arst_n, in_beat |=> (state_q == ST_EVAL))
	`SFR_ASSERT(a_last_ends, clk, arst_n, (emit && emit_last) |=> (state_q == ST_IDLE))
	`SFR_ASSERT_ALWAYS(a_no_emit_idle, clk, (state_q == ST_IDLE) |-> !emit)

endmodule

`default_nettype wire

/* sim/stream_find_replace_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stream_find_replace_test
// Self-checking bench for the stream find-and-replace block. Text beats go
// in through a bursty driver, and rewritten beats are taken by a receiver
// that stalls in changing styles. A software copy of the matching window
// predicts every output beat from the accepted input and the register
// settings. The run starts with directed texts and then moves on to random
// settings and texts that carry many pattern occurrences.
// ----------------------------------------------------------------------------
module stream_find_replace_test;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} text_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       out_last;
	} rewrite_beat_t;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_BURSTY} rx_style_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] data_byte
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;           // [7:0] out_byte
	logic        m_axis_tuser;           // [0] has_byte
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = sfr_pkg::REG_PAT_LO;
	logic [63:0] cfg_data      = 64'h0;

	// predictor copy of the registers and the window
	logic [63:0] pat_lo_r;
	logic [63:0] pat_hi_r;
	logic [4:0]  pat_len_r;
	logic [63:0] rep_w_r [4];
	logic [5:0]  rep_len_r;
	logic [7:0]  win_buf [sfr_pkg::PATTERN_MAX];
	int          win_fill;

	text_beat_t    feed_q [$];
	rewrite_beat_t rewrite_q [$];

	int n_errors    = 0;
	int n_beats_in  = 0;
	int n_beats_out = 0;
	int n_hits      = 0;
	int n_markers   = 0;
	int n_settings  = 0;

	stream_find_replace i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int match_len();
		int n;
		n = int'(pat_len_r);
		if (n == 0)
			n = 1;
		if (n > sfr_pkg::PATTERN_MAX)
			n = sfr_pkg::PATTERN_MAX;
		return n;
	endfunction

	function automatic int subst_len();
		int n;
		n = int'(rep_len_r);
		if (n > sfr_pkg::REPLACE_MAX)
			n = sfr_pkg::REPLACE_MAX;
		return n;
	endfunction

	function automatic logic [7:0] pat_at(int i);
		return (i < 8) ? pat_lo_r[8*i +: 8] : pat_hi_r[8*(i-8) +: 8];
	endfunction

	function automatic logic [7:0] subst_at(int i);
		return rep_w_r[i/8][8*(i%8) +: 8];
	endfunction

	function automatic logic [7:0] pop_window();
		logic [7:0] b;
		b = win_buf[0];
		for (int i = 1; i < win_fill; i++)
			win_buf[i-1] = win_buf[i];
		win_fill--;
		return b;
	endfunction

	function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
		case (idx)
			sfr_pkg::REG_PAT_LO:  pat_lo_r  = val;
			sfr_pkg::REG_PAT_HI:  pat_hi_r  = val;
			sfr_pkg::REG_PAT_LEN: pat_len_r = val[4:0];
			sfr_pkg::REG_REP_W0:  rep_w_r[0] = val;
			sfr_pkg::REG_REP_W1:  rep_w_r[1] = val;
			sfr_pkg::REG_REP_W2:  rep_w_r[2] = val;
			sfr_pkg::REG_REP_W3:  rep_w_r[3] = val;
			sfr_pkg::REG_REP_LEN: rep_len_r = val[5:0];
			default: ;
		endcase
	endfunction

	// advance the window by one text beat and queue the rewritten beats
	function automatic void predict_rewrite(text_beat_t beat);
		logic [7:0]    outs [$];
		int            len;
		bit            hit;
		rewrite_beat_t res;
		len = match_len();
		if (win_fill < sfr_pkg::PATTERN_MAX) begin
			win_buf[win_fill] = beat.data_byte;
			win_fill++;
		end
		if (win_fill > len) begin
			// pattern got shorter: drain down to one short of it, no compare
			while (win_fill > len - 1)
				outs.push_back(pop_window());
		end else if (win_fill == len) begin
			hit = 1'b1;
			for (int i = 0; i < len; i++)
				if (win_buf[i] != pat_at(i))
					hit = 1'b0;
			if (hit) begin
				for (int i = 0; i < subst_len(); i++)
					outs.push_back(subst_at(i));
				win_fill = 0;
				n_hits++;
			end else begin
				outs.push_back(pop_window());
			end
		end
		if (beat.end_of_text)
			while (win_fill > 0)
				outs.push_back(pop_window());
		if (beat.end_of_text && outs.size() == 0) begin
			res.out_byte = 8'h00;
			res.has_byte = 1'b0;
			res.out_last = 1'b1;
			rewrite_q.push_back(res);
			n_markers++;
		end
		foreach (outs[i]) begin
			res.out_byte = outs[i];
			res.has_byte = 1'b1;
			res.out_last = beat.end_of_text && (i == outs.size() - 1);
			rewrite_q.push_back(res);
		end
	endfunction

	// sender: bursts of beats with random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		text_beat_t taken;
		text_beat_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
			s_axis_tlast  <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				taken.data_byte   = s_axis_tdata;
				taken.end_of_text = s_axis_tlast;
				predict_rewrite(taken);
				n_beats_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || feed_q.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					s_axis_tvalid <= 1'b0;
				end else begin
					nxt = feed_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.data_byte;
					s_axis_tlast  <= nxt.end_of_text;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
						if ($urandom_range(0, 15) == 0)
							gap_left = 20;
					end
				end
			end
		end
	end

	// receiver: check each taken beat, then pick the next ready level
	rx_style_t rx_style = RX_FREE;
	int        rx_cycle = 0;
	int        rx_hold  = 0;

	always @(posedge clk or negedge arst_n) begin
		rewrite_beat_t got;
		rewrite_beat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.out_byte = m_axis_tdata;
				got.has_byte = m_axis_tuser;
				got.out_last = m_axis_tlast;
				n_beats_out++;
				if (rewrite_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("%0t: unexpected beat byte=%h has=%b last=%b",
							$realtime, got.out_byte, got.has_byte, got.out_last);
				end else begin
					want = rewrite_q.pop_front();
					if (got.out_byte !== want.out_byte || got.has_byte !== want.has_byte ||
							got.out_last !== want.out_last) begin
						n_errors++;
						if (n_errors <= 10)
							$display("%0t: beat %0d expected byte=%h has=%b last=%b, got byte=%h has=%b last=%b",
								$realtime, n_beats_out, want.out_byte, want.has_byte,
								want.out_last, got.out_byte, got.has_byte, got.out_last);
					end
				end
			end
			rx_cycle++;
			if (rx_cycle % 64 == 0)
				rx_style = rx_style_t'($urandom_range(0, 3));
			case (rx_style)
				RX_FREE:     m_axis_tready <= 1'b1;
				RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
				RX_PERIODIC: m_axis_tready <= ((rx_cycle % 8) < 5);
				default: begin
					if (rx_hold > 0)
						rx_hold--;
					else if ($urandom_range(0, 7) == 0)
						rx_hold = $urandom_range(1, 7);
					m_axis_tready <= (rx_hold == 0);
				end
			endcase
		end
	end

	task automatic push_beat(logic [7:0] b, logic eot);
		text_beat_t t;
		t.data_byte   = b;
		t.end_of_text = eot;
		feed_q.push_back(t);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	// wait for all queued beats to go in and all predicted beats to come out
	task automatic drain(int settle);
		while (feed_q.size() > 0 || s_axis_tvalid || rewrite_q.size() > 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_sym();
		return ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	task automatic random_setup();
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] plen;
		logic [63:0] rlen;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pick_sym();
			hi[8*i +: 8] = pick_sym();
		end
		case ($urandom_range(0, 9))
			0:       plen = 64'd0;
			1:       plen = 64'($urandom_range(17, 31));
			2:       plen = 64'd16;
			3, 4:    plen = 64'd1;
			5:       plen = 64'($urandom_range(7, 16));
			default: plen = 64'($urandom_range(2, 6));
		endcase
		case ($urandom_range(0, 7))
			0:       rlen = 64'd0;
			1:       rlen = 64'($urandom_range(33, 63));
			2:       rlen = 64'd32;
			default: rlen = 64'($urandom_range(0, 8));
		endcase
		write_reg(sfr_pkg::REG_PAT_LO, lo);
		write_reg(sfr_pkg::REG_PAT_HI, hi);
		write_reg(sfr_pkg::REG_PAT_LEN, plen);
		write_reg(sfr_pkg::REG_REP_W0, {$urandom, $urandom});
		write_reg(sfr_pkg::REG_REP_W1, {$urandom, $urandom});
		write_reg(sfr_pkg::REG_REP_W2, {$urandom, $urandom});
		write_reg(sfr_pkg::REG_REP_W3, {$urandom, $urandom});
		write_reg(sfr_pkg::REG_REP_LEN, rlen);
		n_settings++;
	endtask

	// texts rich in whole and partial pattern copies
	task automatic queue_texts(int n_beats, bit leave_open);
		logic [7:0] txt [$];
		int         left;
		int         run;
		int         len;
		int         cut;
		len  = match_len();
		left = n_beats;
		while (left > 0) begin
			txt.delete();
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
			if (run > left)
				run = left;
			while (txt.size() < run) begin
				case ($urandom_range(0, 9))
					0, 1, 2: for (int k = 0; k < len; k++) txt.push_back(pat_at(k));
					3: begin
						cut = $urandom_range(1, len);
						for (int k = 0; k < cut; k++)
							txt.push_back(pat_at(k));
					end
					4, 5, 6: txt.push_back(pat_at($urandom_range(0, len - 1)));
					default: txt.push_back(8'($urandom));
				endcase
			end
			left -= txt.size();
			foreach (txt[i])
				push_beat(txt[i], (i == txt.size() - 1) && !(leave_open && left <= 0));
		end
	endtask

	initial begin
		pat_lo_r  = 64'h0;
		pat_hi_r  = 64'h0;
		pat_len_r = 5'd1;
		for (int i = 0; i < 4; i++)
			rep_w_r[i] = 64'h0;
		rep_len_r = 6'd0;
		win_fill  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: one zero byte is the pattern, an empty replacement deletes it
		push_beat(8'h00, 1'b1);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h00, 1'b0);
		push_beat(8'h80, 1'b1);
		drain(8);

		// full-width pattern and the longest replacement, both given out of range
		write_reg(sfr_pkg::REG_PAT_LO, {8{8'hFF}});
		write_reg(sfr_pkg::REG_PAT_HI, 64'h0);
		write_reg(sfr_pkg::REG_PAT_LEN, 64'd17);
		write_reg(sfr_pkg::REG_REP_W0, {8{8'hFF}});
		write_reg(sfr_pkg::REG_REP_W1, 64'h0);
		write_reg(sfr_pkg::REG_REP_W2, {$urandom, $urandom});
		write_reg(sfr_pkg::REG_REP_W3, {$urandom, $urandom});
		write_reg(sfr_pkg::REG_REP_LEN, 64'd63);
		n_settings += 2;
		for (int i = 0; i < 16; i++)
			push_beat((i < 8) ? 8'hFF : 8'h00, 1'b0);
		// leave a partial match sitting in the window
		push_beat(8'hFF, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h00, 1'b0);
		push_beat(8'h01, 1'b0);
		drain(8);

		// shrink the pattern mid-text; zero length counts as one
		write_reg(sfr_pkg::REG_PAT_LO, 64'h01);
		write_reg(sfr_pkg::REG_PAT_LEN, 64'd0);
		n_settings++;
		push_beat(8'h01, 1'b0);
		push_beat(8'h01, 1'b1);
		drain(8);

		for (int ph = 0; ph < 9; ph++) begin
			random_setup();
			queue_texts(50, (ph < 8) && ($urandom_range(0, 2) == 0));
			drain(8);
		end
		drain(40);

		$display("Sent %0d text beats under %0d register settings", n_beats_in, n_settings);
		$display("Checked %0d output beats: %0d pattern hits, %0d end markers",
			n_beats_out, n_hits, n_markers);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/sfr_pkg.sv
design/sfr_cell.sv
design/sfr_window.sv
design/stream_find_replace.sv
sim/stream_find_replace_test.sv
